// File: rtl/core/slcc_pkg.sv
package slcc_pkg;

    localparam int TAG_BITS    = 32;
    localparam int NUM_SLOTS   = 37;
    localparam int SLOT_BITS   = 6;
    localparam int NUM_CLASSES = 5;
    localparam int WIDTH_BITS  = 10;
    localparam int HEIGHT_BITS = 9;

    typedef logic [SLOT_BITS-1:0]   slot_idx_t;
    typedef logic [WIDTH_BITS-1:0]  pic_width_t;
    typedef logic [HEIGHT_BITS-1:0] pic_height_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        pic_width_t          pic_width;
        pic_height_t         pic_height;
    } slot_entry_t;

    typedef struct packed {
        logic      fits;
        slot_idx_t first;
        slot_idx_t last;
    } class_pick_t;

    localparam slot_idx_t CLASS_FIRST [NUM_CLASSES] = '{6'd0, 6'd10, 6'd20, 6'd25, 6'd27};
    localparam slot_idx_t CLASS_LAST  [NUM_CLASSES] = '{6'd9, 6'd19, 6'd24, 6'd26, 6'd36};
    localparam pic_width_t CLASS_W [NUM_CLASSES] =
        '{10'd60, 10'd250, 10'd300, 10'd800, 10'd800};
    localparam pic_height_t CLASS_H [NUM_CLASSES] =
        '{9'd60, 9'd40, 9'd400, 9'd90, 9'd480};

    function automatic class_pick_t pick_class(pic_width_t w, pic_height_t h);
        class_pick_t res;
        res = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (CLASS_W[c] >= w && CLASS_H[c] >= h) begin
                res.fits  = 1'b1;
                res.first = CLASS_FIRST[c];
                res.last  = CLASS_LAST[c];
            end
        end
        return res;
    endfunction

    function automatic slot_idx_t group_end(slot_idx_t s);
        slot_idx_t res;
        res = s;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (s >= CLASS_FIRST[c] && s <= CLASS_LAST[c]) begin
                res = CLASS_LAST[c];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/size_class_lru_slot_cache.sv
// channel | dir | tdata (low bit up)                          | tuser (low bit up)
// s_      | in  | name_tag[31:0] req_width[41:32]             | -
//         |     | req_height[50:42], zero pad to 56            |
// m_      | out | slot_index[5:0] stored_width[15:6]          | hit[0] no_fit[1]
//         |     | stored_height[24:16], zero pad to 32         |
// One word at a time: the tag search reads one slot per cycle from the
// registered RAM read and stops at the first hit, all 37 slots on a miss.
// A hit or a fill then rotates the class group one slot per cycle after one
// priming read (up to 9 steps), writes the group end, and loads the result
// register. Reset clears every valid bit at once.
// A result waiting on m_tready stalls only the final step.
module size_class_lru_slot_cache
    import slcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // name_tag, req_width, req_height
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // slot_index, stored_width, stored_height
    output logic [1:0]  m_tuser   // hit, no_fit
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_ROT,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    pic_width_t           width_reg;
    pic_height_t          height_reg;
    slot_idx_t            rd_ptr_reg;
    slot_idx_t            cmp_ptr_reg;
    logic                 cmp_live_reg;
    slot_idx_t            wr_ptr_reg;
    slot_idx_t            end_reg;
    logic                 primed_reg;
    logic                 hit_reg;
    logic                 nofit_reg;
    slot_entry_t          hold_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    logic        ram_wr_en;
    slot_idx_t   ram_wr_addr;
    slot_entry_t ram_wr_data;
    slot_entry_t ram_rd_data;
    slot_entry_t new_entry;
    logic        match;
    class_pick_t pick;
    slot_idx_t   found_end;

    slcc_slot_ram u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        new_entry.tag        = tag_reg;
        new_entry.pic_width  = width_reg;
        new_entry.pic_height = height_reg;
        ram_wr_en   = (state_reg == ST_ROT && primed_reg) || state_reg == ST_FILL;
        ram_wr_addr = (state_reg == ST_FILL) ? end_reg : wr_ptr_reg;
        if (state_reg == ST_FILL) begin
            ram_wr_data = hit_reg ? hold_reg : new_entry;
        end else begin
            ram_wr_data = ram_rd_data;
        end
        match     = cmp_live_reg && valid_reg[cmp_ptr_reg] && ram_rd_data.tag == tag_reg;
        pick      = pick_class(width_reg, height_reg);
        found_end = group_end(cmp_ptr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cmp_live_reg <= 1'b0;
            primed_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        tag_reg      <= s_tdata[TAG_BITS-1:0];
                        width_reg    <= s_tdata[41:32];
                        height_reg   <= s_tdata[50:42];
                        rd_ptr_reg   <= '0;
                        cmp_live_reg <= 1'b0;
                        hit_reg      <= 1'b0;
                        nofit_reg    <= 1'b0;
                        state_reg    <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (match) begin
                        hit_reg      <= 1'b1;
                        hold_reg     <= ram_rd_data;
                        end_reg      <= found_end;
                        wr_ptr_reg   <= cmp_ptr_reg;
                        cmp_live_reg <= 1'b0;
                        primed_reg   <= 1'b0;
                        rd_ptr_reg   <= cmp_ptr_reg + 1'b1;
                        state_reg    <= (cmp_ptr_reg == found_end) ? ST_FILL : ST_ROT;
                    end else if (cmp_live_reg &&
                                 cmp_ptr_reg == slot_idx_t'(NUM_SLOTS - 1)) begin
                        cmp_live_reg <= 1'b0;
                        if (!pick.fits) begin
                            nofit_reg <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            end_reg    <= pick.last;
                            wr_ptr_reg <= pick.first;
                            primed_reg <= 1'b0;
                            rd_ptr_reg <= pick.first + 1'b1;
                            state_reg  <= (pick.first == pick.last) ? ST_FILL : ST_ROT;
                        end
                    end else begin
                        cmp_ptr_reg  <= rd_ptr_reg;
                        cmp_live_reg <= 1'b1;
                        if (rd_ptr_reg != slot_idx_t'(NUM_SLOTS - 1)) begin
                            rd_ptr_reg <= rd_ptr_reg + 1'b1;
                        end
                    end
                end
                ST_ROT: begin
                    primed_reg <= 1'b1;
                    if (rd_ptr_reg != end_reg) begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end
                    if (primed_reg) begin
                        valid_reg[wr_ptr_reg] <= valid_reg[slot_idx_t'(wr_ptr_reg + 1'b1)];
                        wr_ptr_reg <= wr_ptr_reg + 1'b1;
                        if (slot_idx_t'(wr_ptr_reg + 1'b1) == end_reg) begin
                            state_reg <= ST_FILL;
                        end
                    end
                end
                ST_FILL: begin
                    valid_reg[end_reg] <= 1'b1;
                    state_reg          <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {nofit_reg, hit_reg};
                        if (nofit_reg) begin
                            m_tdata_reg <= '0;
                        end else if (hit_reg) begin
                            m_tdata_reg <= {7'd0, hold_reg.pic_height,
                                            hold_reg.pic_width, end_reg};
                        end else begin
                            m_tdata_reg <= {7'd0, height_reg, width_reg, end_reg};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_hit_nofit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("hit and no_fit both set");

    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg[1]) |-> (m_tdata_reg == '0))
        else $error("no_fit word carries nonzero data");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[5:0] <= slot_idx_t'(NUM_SLOTS - 1)))
        else $error("slot index out of range");

    a_result_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg[1]) |-> valid_reg[m_tdata_reg[5:0]])
        else $error("returned slot not valid");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");
`endif

endmodule

// File: rtl/core/slcc_slot_ram.sv
module slcc_slot_ram
    import slcc_pkg::*;
(
    input  logic        aclk,
    input  logic        wr_en,
    input  slot_idx_t   wr_addr,
    input  slot_entry_t wr_data,
    input  slot_idx_t   rd_addr,
    output slot_entry_t rd_data
);

    slot_entry_t mem_reg [NUM_SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
